// ----- hdl/frustum_box_cull_assert.svh -----
// Assertion macros for the frustum box cull block.
// Included by the RTL files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked on clk, off while rst_n is low
`define FBC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, checked during reset too
`define FBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FBC_ASSERT_CLK(lbl, prop, msg)
`define FBC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hdl/fbc_pkg.sv -----
// Shared constants, types and plane decode functions of the frustum box cull block.
// No dependencies; imported by every other file of the block but the assertion header.
`default_nettype none

package fbc_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int VAL_W      = 32;
    localparam int IDX_W      = 4;
    localparam int MAT_DEPTH  = 16;
    localparam int CHUNK_W    = 31;
    localparam int NUM_PLANES = 6;
    localparam int PLANE_W    = 3;
    localparam int AXIS_W     = 2;
    localparam int PV_W       = VAL_W + 1;
    localparam int COORD_W    = VAL_W + 2;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 31'd65536;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    localparam logic [PLANE_W-1:0] PLANE_LEFT   = 3'd0;
    localparam logic [PLANE_W-1:0] PLANE_RIGHT  = 3'd1;
    localparam logic [PLANE_W-1:0] PLANE_BOTTOM = 3'd2;
    localparam logic [PLANE_W-1:0] PLANE_TOP    = 3'd3;
    localparam logic [PLANE_W-1:0] PLANE_NEAR   = 3'd4;
    localparam logic [PLANE_W-1:0] PLANE_FAR    = 3'd5;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic               mat_we;
        logic               box_load;
        logic               issue;
        logic [PLANE_W-1:0] plane;
        logic               result_load;
    } fbc_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } fbc_status_t;

    // Row 3 minus the axis row on these planes, plus on the others
    function automatic logic plane_negates(input logic [PLANE_W-1:0] plane);
        logic neg;
        unique case (plane)
            PLANE_RIGHT, PLANE_BOTTOM, PLANE_FAR: neg = 1'b1;
            default:                              neg = 1'b0;
        endcase
        return neg;
    endfunction

    function automatic logic [AXIS_W-1:0] plane_axis(input logic [PLANE_W-1:0] plane);
        return plane[PLANE_W-1:1];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fbc_if.sv -----
// Valid/ready channel interfaces of the frustum box cull block: input items and results.
// Depends on fbc_pkg for field widths.
`default_nettype none

interface fbc_item_if;
    import fbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [IDX_W-1:0]        matrix_index;
    logic signed [VAL_W-1:0] matrix_value;
    logic signed [VAL_W-1:0] center_x;
    logic signed [VAL_W-1:0] center_y;
    logic signed [VAL_W-1:0] center_z;

    modport source (
        output valid, cmd, matrix_index, matrix_value, center_x, center_y, center_z,
        input  ready
    );

    modport sink (
        input  valid, cmd, matrix_index, matrix_value, center_x, center_y, center_z,
        output ready
    );
endinterface

interface fbc_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );

    modport sink (
        input  valid, visible,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/frustum_box_cull.sv -----
// Top level of the frustum box cull block: controller, datapath and channel wiring.
// Depends on fbc_pkg, fbc_if, fbc_ctrl and fbc_datapath.
//
// Frustum test of an axis-aligned box against the six clip planes of a view-projection
// matrix held in Q(FRAC_BITS) fixed point. A matrix write item (cmd 0) is taken without
// leaving idle and gives no result. A box test item (cmd 1) gives one visible bit: the six
// planes are issued in turn through a shared set of three 33x34 multipliers, the multiply
// and adder-tree stages drain, and the result register is loaded once it is free; no
// further item is accepted until it is loaded. A finished result waits in its own register;
// a following write item is still accepted while it waits. The user must write chunk_size
// through cfg_we/cfg_wdata while the block is idle, which it does not enforce; it resets to 65536.
`default_nettype none

module frustum_box_cull #(
    parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fbc_pkg::CHUNK_W-1:0] cfg_wdata,
    fbc_item_if.sink                    items,
    fbc_result_if.source                results
);
    import fbc_pkg::*;

    fbc_cmd_t    cmd;
    fbc_status_t status;
    logic        in_ready;
    logic        out_valid;
    logic        visible;

    fbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_cmd    (items.cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    fbc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .matrix_index (items.matrix_index),
        .matrix_value (items.matrix_value),
        .center_x     (items.center_x),
        .center_y     (items.center_y),
        .center_z     (items.center_z),
        .cmd          (cmd),
        .status       (status),
        .visible      (visible)
    );

    assign items.ready     = in_ready;
    assign results.valid   = out_valid;
    assign results.visible = visible;

endmodule

`default_nettype wire

// ----- hdl/fbc_ctrl.sv -----
// Controller of the frustum box cull block: accepts items, sequences the six planes, owns result valid.
// Depends on fbc_pkg and frustum_box_cull_assert.svh.
`default_nettype none
`include "frustum_box_cull_assert.svh"

module fbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output fbc_pkg::fbc_cmd_t    cmd,
    input  fbc_pkg::fbc_status_t status
);
    import fbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ISSUE  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic               out_valid_reg, out_valid_next;
    logic               in_xfer;
    logic               result_free;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign result_free = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_cmd == CMD_TEST)
                    begin
                        cmd.box_load = 1'b1;
                        state_next   = S_ISSUE;
                    end
                    else
                    begin
                        cmd.mat_we = 1'b1;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.issue = 1'b1;
                cmd.plane = plane_reg;
                if (plane_reg == PLANE_W'(NUM_PLANES - 1))
                begin
                    plane_next = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                // hold until the pipeline drains and the result register frees
                if (!status.pipe_busy && result_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                plane_next = '0;
            end
        endcase

        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plane_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FBC_ASSERT_CLK(a_plane_range, cmd.issue |-> (cmd.plane < PLANE_W'(NUM_PLANES)), "plane out of range")
    `FBC_ASSERT_CLK(a_test_starts, (in_xfer && in_cmd == CMD_TEST) |=> (state_reg == S_ISSUE), "test did not start")
    `FBC_ASSERT_CLK(a_all_planes, $rose(state_reg == S_FINISH) |-> ($past(plane_reg) == PLANE_W'(NUM_PLANES - 1)), "planes skipped")
    `FBC_ASSERT_CLK(a_idle_empty, (state_reg == S_IDLE) |-> !status.pipe_busy, "pipeline busy while idle")
    `FBC_ASSERT_ALWAYS(a_idle_plane, (state_reg == S_IDLE) |-> (plane_reg == '0), "plane counter not cleared")

endmodule

`default_nettype wire

// ----- hdl/fbc_datapath.sv -----
// Datapath of the frustum box cull block: matrix and chunk size registers, box corners,
// plane select, shared multipliers and sign test. Depends on fbc_pkg.
`default_nettype none

module fbc_datapath #(
    parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbc_pkg::CHUNK_W-1:0]       cfg_wdata,
    input  logic [fbc_pkg::IDX_W-1:0]         matrix_index,
    input  logic signed [fbc_pkg::VAL_W-1:0]  matrix_value,
    input  logic signed [fbc_pkg::VAL_W-1:0]  center_x,
    input  logic signed [fbc_pkg::VAL_W-1:0]  center_y,
    input  logic signed [fbc_pkg::VAL_W-1:0]  center_z,
    input  fbc_pkg::fbc_cmd_t                 cmd,
    output fbc_pkg::fbc_status_t              status,
    output logic                              visible
);
    import fbc_pkg::*;

    localparam int PROD_W = PV_W + COORD_W;
    localparam int SUM_W  = PROD_W + 2;

    logic [CHUNK_W-1:0]        chunk_reg;
    logic signed [VAL_W-1:0]   mat_reg [MAT_DEPTH];

    logic signed [COORD_W-1:0] lo_reg [3];
    logic signed [COORD_W-1:0] hi_reg [3];
    logic signed [COORD_W-1:0] lo_next [3];
    logic signed [COORD_W-1:0] hi_next [3];

    logic signed [PV_W-1:0]    p_next [4];
    logic signed [COORD_W-1:0] coord_next [3];
    logic signed [PV_W-1:0]    p1_reg [4];
    logic signed [COORD_W-1:0] c1_reg [3];
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [SUM_W-1:0]   w2_reg;
    logic signed [SUM_W-1:0]   s01_reg;
    logic signed [SUM_W-1:0]   s23_reg;
    logic signed [SUM_W-1:0]   total;

    logic v1_reg, v2_reg, v3_reg;
    logic cull_reg, cull_next;
    logic visible_reg;

    logic signed [COORD_W-1:0] cx2, cy2, cz2, cs_ext;
    logic [AXIS_W-1:0]         axis;
    logic                      neg;

    // doubled box corners
    always_comb
    begin
        cx2    = COORD_W'(center_x) <<< 1;
        cy2    = COORD_W'(center_y) <<< 1;
        cz2    = COORD_W'(center_z) <<< 1;
        cs_ext = COORD_W'(chunk_reg);
        lo_next[0] = cx2 - cs_ext;
        hi_next[0] = cx2 + cs_ext;
        lo_next[1] = cy2;
        hi_next[1] = cy2 + (cs_ext <<< 1);
        lo_next[2] = cz2 - cs_ext;
        hi_next[2] = cz2 + cs_ext;
    end

    // plane coefficients and maximizing corner for the issued plane
    always_comb
    begin
        logic signed [PV_W-1:0] a;
        logic signed [PV_W-1:0] b;
        axis = plane_axis(cmd.plane);
        neg  = plane_negates(cmd.plane);
        for (int c = 0; c < 4; c++)
        begin
            a = PV_W'(mat_reg[IDX_W'(c * 4 + 3)]);
            unique case (axis)
                AXIS_X:  b = PV_W'(mat_reg[IDX_W'(c * 4)]);
                AXIS_Y:  b = PV_W'(mat_reg[IDX_W'(c * 4 + 1)]);
                AXIS_Z:  b = PV_W'(mat_reg[IDX_W'(c * 4 + 2)]);
                default: b = PV_W'(mat_reg[IDX_W'(c * 4 + 2)]);
            endcase
            p_next[c] = neg ? (a - b) : (a + b);
        end
        for (int c = 0; c < 3; c++)
        begin
            coord_next[c] = p_next[c][PV_W-1] ? lo_reg[c] : hi_reg[c];
        end
    end

    assign total = s01_reg + s23_reg;

    always_comb
    begin
        cull_next = cull_reg;
        if (cmd.box_load)
        begin
            cull_next = 1'b0;
        end
        else if (v3_reg && total[SUM_W-1])
        begin
            cull_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_RESET;
            for (int i = 0; i < MAT_DEPTH; i++)
            begin
                mat_reg[i] <= '0;
            end
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            cull_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                chunk_reg <= cfg_wdata;
            end
            if (cmd.mat_we)
            begin
                mat_reg[matrix_index] <= matrix_value;
            end
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            cull_reg <= cull_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.box_load)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lo_reg[c] <= lo_next[c];
                hi_reg[c] <= hi_next[c];
            end
        end
        if (cmd.issue)
        begin
            for (int c = 0; c < 4; c++)
            begin
                p1_reg[c] <= p_next[c];
            end
            for (int c = 0; c < 3; c++)
            begin
                c1_reg[c] <= coord_next[c];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= p1_reg[c] * c1_reg[c];
        end
        w2_reg  <= SUM_W'(p1_reg[3]) <<< (FRAC_BITS + 1);
        s01_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
        s23_reg <= SUM_W'(prod_reg[2]) + w2_reg;
        if (cmd.result_load)
        begin
            visible_reg <= ~cull_reg;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign visible          = visible_reg;

endmodule

`default_nettype wire

// ----- sim/frustum_box_cull_test.sv -----
// Self-checking testbench of frustum_box_cull: directed table then random matrix/box traffic.
// Depends on fbc_pkg and the fbc_item_if/fbc_result_if interfaces of the RTL.
// Box tests are checked against an in-bench predictor of the six-plane cull or a known result.
`default_nettype none

module frustum_box_cull_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbc_pkg::*;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_TEN  = 32'h000A_0000;
    localparam logic [31:0] Q_MTEN = 32'hFFF6_0000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam int          ROWS   = 21;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic        known;
        logic        vis;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CHUNK_W-1:0] cfg_wdata;

    fbc_item_if   items_if();
    fbc_result_if results_if();

    frustum_box_cull dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (items_if),
        .results   (results_if)
    );

    logic signed [31:0] matrix_copy [16];
    logic [CHUNK_W-1:0] chunk_copy;
    bit                 visible_expected [$];
    int                 error_count;
    bit                 steady_run;

    stim_row_t directed_rows [ROWS] = '{
        '{CMD_TEST,  4'd0,  32'd0,        32'd0,  32'd0,  32'd0,  1'b1, 1'b1},
        '{CMD_TEST,  4'd15, 32'hFFFF_FFFF, Q_MIN, Q_MAX,  Q_MIN,  1'b1, 1'b1},
        '{CMD_TEST,  4'd0,  Q_MAX,        Q_MAX,  Q_MIN,  Q_MAX,  1'b1, 1'b1},
        '{CMD_WRITE, 4'd0,  Q_ONE,        Q_MAX,  Q_MIN,  32'd0,  1'b0, 1'b0},
        '{CMD_WRITE, 4'd5,  Q_ONE,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_WRITE, 4'd10, Q_ONE,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_WRITE, 4'd15, Q_ONE,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        Q_MTEN, 32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        Q_TEN,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        32'd0,  Q_MTEN, 32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        32'd0,  Q_TEN,  32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        32'd0,  32'd0,  Q_MTEN, 1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        32'd0,  32'd0,  Q_TEN,  1'b0, 1'b0},
        '{CMD_WRITE, 4'd15, Q_MIN,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_WRITE, 4'd3,  Q_MAX,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        Q_MAX,  Q_MAX,  Q_MAX,  1'b0, 1'b0},
        '{CMD_TEST,  4'd0,  32'd0,        Q_MIN,  Q_MIN,  Q_MIN,  1'b0, 1'b0},
        '{CMD_WRITE, 4'd3,  32'd0,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_WRITE, 4'd15, Q_ONE,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0},
        '{CMD_TEST,  4'd5,  Q_MIN,        32'd0,  32'd0,  32'd0,  1'b0, 1'b0}
    };

    function automatic bit box_in_view(input logic signed [31:0] cx,
                                       input logic signed [31:0] cy,
                                       input logic signed [31:0] cz);
        logic signed [35:0]  span;
        logic signed [35:0]  low_c [3];
        logic signed [35:0]  high_c [3];
        logic signed [35:0]  coord;
        logic signed [33:0]  coef;
        logic signed [127:0] acc;
        logic [PLANE_W-1:0]  plane;
        int                  axis;
        bit                  flip;
        span = {5'b0, chunk_copy};
        low_c[0]  = 2 * cx - span;
        high_c[0] = 2 * cx + span;
        low_c[1]  = 2 * cy;
        high_c[1] = 2 * cy + 2 * span;
        low_c[2]  = 2 * cz - span;
        high_c[2] = 2 * cz + span;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane = PLANE_W'(p);
            axis  = p / 2;
            flip  = (plane == PLANE_RIGHT) || (plane == PLANE_BOTTOM) || (plane == PLANE_FAR);
            acc   = '0;
            for (int col = 0; col < 4; col++)
            begin
                if (flip)
                    coef = matrix_copy[col * 4 + 3] - matrix_copy[col * 4 + axis];
                else
                    coef = matrix_copy[col * 4 + 3] + matrix_copy[col * 4 + axis];
                if (col == 3)
                    coord = 36'sd1 <<< (FRAC_BITS_DEFAULT + 1);
                else
                    coord = (coef >= 0) ? high_c[col] : low_c[col];
                acc = acc + coef * coord;
            end
            if (acc < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] wide_value();
        case ($urandom_range(9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2, 3, 4: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        row.cmd   = 1'($urandom_range(1));
        row.idx   = 4'($urandom_range(15));
        row.value = $urandom;
        row.cx    = $urandom;
        row.cy    = $urandom;
        row.cz    = $urandom;
        row.known = 1'b0;
        row.vis   = 1'b0;
        return row;
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (visible_expected.size() == 0)
                begin
                    $error("visible: no result expected, got %0b", results_if.visible);
                    error_count++;
                end
                else if (results_if.visible !== visible_expected[0])
                begin
                    $error("visible: expected %0b, got %0b", visible_expected[0],
                           results_if.visible);
                    error_count++;
                    void'(visible_expected.pop_front());
                end
                else
                begin
                    void'(visible_expected.pop_front());
                end
            end
            results_if.ready <= steady_run || ($urandom_range(99) >= 11);
        end
    end

    task automatic send_item(input stim_row_t row);
        bit vis;
        while (!steady_run && $urandom_range(99) < 11)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid        <= 1'b1;
        items_if.cmd          <= row.cmd;
        items_if.matrix_index <= row.idx;
        items_if.matrix_value <= row.value;
        items_if.center_x     <= row.cx;
        items_if.center_y     <= row.cy;
        items_if.center_z     <= row.cz;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        if (row.cmd == CMD_WRITE)
        begin
            matrix_copy[row.idx] = row.value;
        end
        else
        begin
            vis = row.known ? row.vis : box_in_view(row.cx, row.cy, row.cz);
            visible_expected = {visible_expected, vis};
        end
    endtask

    task automatic drain();
        items_if.valid <= 1'b0;
        while (visible_expected.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_chunk(input logic [CHUNK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        chunk_copy = value;
    endtask

    // A full matrix load at moderate scale then boxes near the frustum, or a lone item.
    task automatic run_random(input int count);
        stim_row_t row;
        int        sent;
        int        boxes;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(5) == 0)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    row       = random_row();
                    row.cmd   = CMD_WRITE;
                    row.idx   = 4'(i);
                    row.value = $signed($urandom) >>> $urandom_range(12, 18);
                    send_item(row);
                end
                sent  += 16;
                boxes  = $urandom_range(8, 24);
                for (int i = 0; i < boxes; i++)
                begin
                    row     = random_row();
                    row.cmd = CMD_TEST;
                    row.cx  = $signed($urandom) >>> $urandom_range(8, 14);
                    row.cy  = $signed($urandom) >>> $urandom_range(8, 14);
                    row.cz  = $signed($urandom) >>> $urandom_range(8, 14);
                    send_item(row);
                end
                sent += boxes;
            end
            else if ($urandom_range(3) == 0)
            begin
                row       = random_row();
                row.value = wide_value();
                row.cx    = wide_value();
                row.cy    = wide_value();
                row.cz    = wide_value();
                send_item(row);
                sent++;
            end
            else
            begin
                row     = random_row();
                row.cmd = CMD_TEST;
                row.cx  = $signed($urandom) >>> $urandom_range(6, 16);
                row.cy  = $signed($urandom) >>> $urandom_range(6, 16);
                row.cz  = $signed($urandom) >>> $urandom_range(6, 16);
                send_item(row);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [CHUNK_W-1:0] chunk_value;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        items_if.valid        = 1'b0;
        items_if.cmd          = CMD_WRITE;
        items_if.matrix_index = '0;
        items_if.matrix_value = '0;
        items_if.center_x     = '0;
        items_if.center_y     = '0;
        items_if.center_z     = '0;
        error_count           = 0;
        steady_run            = 1'b0;
        chunk_copy            = CHUNK_RESET;
        for (int i = 0; i < 16; i++)
            matrix_copy[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROWS; r++)
            send_item(directed_rows[r]);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       chunk_value = '0;
                1:       chunk_value = 31'h7FFF_FFFF;
                2:       chunk_value = 31'd65536;
                3:       chunk_value = 31'd1;
                4:       chunk_value = CHUNK_W'($urandom_range(1 << 20));
                default: chunk_value = CHUNK_W'($urandom);
            endcase
            drain();
            write_chunk(chunk_value);
            steady_run = (phase == 2);
            if (phase == 1)
            begin
                run_random(140);
                drain();
                run_random(140);
            end
            else
            begin
                run_random(285);
            end
        end
        steady_run = 1'b0;

        drain();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/fbc_pkg.sv
hdl/fbc_if.sv
hdl/fbc_ctrl.sv
hdl/fbc_datapath.sv
hdl/frustum_box_cull.sv
sim/frustum_box_cull_test.sv
